[sv/tbma_pkg.sv]
// shared types and constants of the time bucket aggregator
package tbma_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int SUM_BITS       = 44;
  localparam logic [31:0] MIN_STAMP = 32'd1700000000;

  localparam logic [16:0] BS_RESET = 17'd60;
  localparam logic [22:0] MP_RESET = 23'd400000;
  localparam logic [31:0] ME_RESET = 32'd4000000000;

  typedef enum logic [1:0] {
    REG_BUCKET_SECONDS = 2'd0,
    REG_MAX_POWER      = 2'd1,
    REG_MAX_ENERGY     = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_EMIT_ADD  = 3'd1,
    ST_BACKWARDS = 3'd2,
    ST_WRITTEN   = 3'd3,
    ST_HELD      = 3'd4,
    ST_NOTHING   = 3'd5,
    ST_FLUSHED   = 3'd6
  } status_t;

  // one accepted request as it travels through the queue
  typedef struct packed {
    logic        req_type;
    logic [31:0] epoch;
    logic [23:0] power;
    logic        power_ok;
    logic [31:0] import_energy;
    logic        import_ok;
    logic [31:0] export_energy;
    logic        export_ok;
  } req_t;

  localparam int REQ_BITS = $bits(req_t);

  // one result beat
  typedef struct packed {
    status_t     status;
    logic [31:0] bucket_start;
    logic [23:0] mean_power;
    logic [23:0] min_power;
    logic [23:0] max_power_seen;
    logic [31:0] import_out;
    logic        import_known;
    logic [31:0] export_out;
    logic        export_known;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MOD,
    BK_DECIDE,
    BK_DIV,
    BK_CHECK,
    BK_OUT
  } bk_state_t;

endpackage

[sv/tbma_fifo.sv]
// short request queue between front and back
module tbma_fifo
  import tbma_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  req_t  wr_data,
  output logic  full,
  input  logic  rd_en,
  output req_t  rd_data,
  output logic  empty
);

  req_t       mem_r [2];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en || rd_en) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !rd_en) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");

endmodule

[sv/tbma_back.sv]
// aggregation engine: bucket modulo, mean divider, plausibility check
module tbma_back
  import tbma_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [16:0] bucket_seconds,
  input  logic [22:0] max_power,
  input  logic [31:0] max_energy,
  input  logic        q_empty,
  input  req_t        q_data,
  output logic        q_rd,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        out_res
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  bk_state_t state_r, state_nxt;

  // aggregate state
  logic                  open_r;
  logic [31:0]           open_bucket_r;
  logic signed [SUM_BITS-1:0] sum_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic signed [23:0]    min_r, max_r;
  logic                  mm_known_r;
  logic [31:0]           imp_r, exp_r;
  logic                  imp_k_r, exp_k_r;
  logic [31:0]           last_r;

  // work registers
  req_t        req_r;
  logic [31:0] rem_r, bucket_r;
  logic [5:0]  step_r;
  logic [SUM_BITS-1:0] dq_r;
  logic [COUNT_BITS:0] dr_r;
  logic signed [24:0]  mean_r;
  logic        emitted_r;
  res_t        res_r;
  logic        ov_r;

  logic [16:0] bs;
  logic [32:0] rem_sh;
  logic [32:0] rem_try;
  logic [COUNT_BITS:0] dr_sh;
  logic [SUM_BITS-1:0] sum_mag;
  logic        ok;
  logic signed [24:0] mn, mx, mp;
  logic [24:0] mean_abs;
  logic        mean_neg;
  logic [31:0] bkt;
  logic        bk_back;
  logic        bk_rewrite;
  logic        need_emit;
  res_t        res_d;

  assign bs        = (bucket_seconds == 17'd0) ? 17'd1 : bucket_seconds;
  assign rem_sh    = {rem_r, req_r.epoch[5'd31 - step_r[4:0]]};
  assign rem_try   = rem_sh - {16'd0, bs};
  assign dr_sh     = {dr_r[COUNT_BITS-1:0], dq_r[SUM_BITS-1]};
  assign sum_mag   = sum_r[SUM_BITS-1] ? SUM_BITS'(-sum_r) : SUM_BITS'(sum_r);
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign q_rd      = (state_r == BK_IDLE) && !q_empty && !ov_r;

  // bucket of the request and its classification at decide
  assign bkt        = bucket_r - rem_r;
  assign bk_back    = (bkt < last_r) || (open_r && bkt < open_bucket_r);
  assign bk_rewrite = !open_r && (last_r == bkt);

  // an emit is due on a flush of a filled bucket or a sample of a new bucket
  always_comb begin
    if (req_r.req_type) need_emit = open_r && cnt_r != '0;
    else need_emit = !bk_back && !bk_rewrite && open_r && bkt != open_bucket_r &&
                     cnt_r != '0;
  end

  // plausibility of the record formed from the registered mean
  assign mn       = 25'(min_r);
  assign mx       = 25'(max_r);
  assign mp       = $signed({2'b00, max_power});
  assign mean_neg = mean_r[24];
  assign mean_abs = mean_neg ? 25'(-mean_r) : 25'(mean_r);
  always_comb begin
    ok = (open_bucket_r >= MIN_STAMP) &&
         (mean_abs <= {2'b00, max_power}) &&
         (mn <= mp) && (-mn <= mp) && (mx <= mp) && (-mx <= mp) &&
         (mn <= mx) && (mean_r >= mn) && (mean_r <= mx) &&
         (!imp_k_r || imp_r <= max_energy) &&
         (!exp_k_r || exp_r <= max_energy);
  end

  // result beat formed at decide or at check
  always_comb begin
    res_d = '0;
    if (state_r == BK_CHECK) begin
      if (ok) begin
        res_d.status         = req_r.req_type ? ST_FLUSHED : ST_EMIT_ADD;
        res_d.bucket_start   = open_bucket_r;
        res_d.mean_power     = mean_r[23:0];
        res_d.min_power      = min_r;
        res_d.max_power_seen = max_r;
        res_d.import_out     = imp_k_r ? imp_r : 32'd0;
        res_d.import_known   = imp_k_r;
        res_d.export_out     = exp_k_r ? exp_r : 32'd0;
        res_d.export_known   = exp_k_r;
      end else begin
        res_d.status = ST_HELD;
      end
    end else if (req_r.req_type) begin
      res_d.status = ST_NOTHING;
    end else if (bk_back) begin
      res_d.status = ST_BACKWARDS;
    end else if (bk_rewrite) begin
      res_d.status = ST_WRITTEN;
    end else begin
      res_d.status = ST_ADDED;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:   if (q_rd) state_nxt = BK_MOD;
      BK_MOD:    if (step_r == 6'd31) state_nxt = BK_DECIDE;
      BK_DECIDE: state_nxt = need_emit ? BK_DIV : BK_IDLE;
      BK_DIV:    if (step_r == 6'(SUM_BITS - 1)) state_nxt = BK_CHECK;
      BK_CHECK:  state_nxt = BK_OUT;
      BK_OUT:    state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // output beat valid: set at decide without emit or after check
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if ((state_r == BK_DECIDE && !need_emit) || state_r == BK_OUT) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0; open_bucket_r <= '0; sum_r <= '0; cnt_r <= '0;
      min_r <= '0; max_r <= '0; mm_known_r <= 1'b0;
      imp_r <= '0; exp_r <= '0; imp_k_r <= 1'b0; exp_k_r <= 1'b0;
      last_r <= '0;
    end else begin
      case (state_r)
        BK_IDLE: begin
          if (q_rd) begin
            req_r  <= q_data;
            rem_r  <= '0;
            step_r <= '0;
          end
        end
        BK_MOD: begin
          // restoring remainder, one epoch bit a cycle
          rem_r  <= rem_try[32] ? rem_sh[31:0] : rem_try[31:0];
          step_r <= step_r + 6'd1;
          if (step_r == 6'd31) bucket_r <= req_r.epoch;
        end
        BK_DECIDE: begin
          // bucket is now epoch - rem; classified below
        end
        BK_DIV: begin
          dr_r   <= (dr_sh >= {1'b0, cnt_r}) ? dr_sh - {1'b0, cnt_r} : dr_sh;
          dq_r   <= {dq_r[SUM_BITS-2:0], (dr_sh >= {1'b0, cnt_r})};
          step_r <= step_r + 6'd1;
          if (step_r == 6'(SUM_BITS - 1)) begin
            mean_r <= sum_r[SUM_BITS-1]
              ? -$signed({1'b0, dq_r[22:0], (dr_sh >= {1'b0, cnt_r})})
              : $signed({1'b0, dq_r[22:0], (dr_sh >= {1'b0, cnt_r})});
          end
        end
        BK_CHECK: begin
          res_r <= res_d;
          if (ok) begin
            last_r <= open_bucket_r;
            open_r <= 1'b0; open_bucket_r <= '0; sum_r <= '0; cnt_r <= '0;
            min_r <= '0; max_r <= '0; mm_known_r <= 1'b0;
            imp_r <= '0; exp_r <= '0; imp_k_r <= 1'b0; exp_k_r <= 1'b0;
          end
          emitted_r <= ok;
        end
        BK_OUT: begin
          // flush beats and held records go out; an emitting sample joins
          if (!req_r.req_type && emitted_r) begin
            open_r        <= 1'b1;
            open_bucket_r <= bucket_r;
            if (req_r.power_ok) begin
              sum_r <= SUM_BITS'($signed(req_r.power));
              cnt_r <= COUNT_BITS'(1);
              min_r <= req_r.power; max_r <= req_r.power; mm_known_r <= 1'b1;
            end
            if (req_r.import_ok) begin imp_r <= req_r.import_energy; imp_k_r <= 1'b1; end
            if (req_r.export_ok) begin exp_r <= req_r.export_energy; exp_k_r <= 1'b1; end
          end
        end
        default: ;
      endcase

      // classification once the bucket is known
      if (state_r == BK_DECIDE) begin
        if (!need_emit) res_r <= res_d;
        if (!req_r.req_type && !bk_back && !bk_rewrite && !need_emit) begin
          if (!open_r) begin
            open_r <= 1'b1;
            open_bucket_r <= bkt;
          end
          if (req_r.power_ok) begin
            if (cnt_r != COUNT_MAX) begin
              sum_r <= sum_r + SUM_BITS'($signed(req_r.power));
              cnt_r <= cnt_r + COUNT_BITS'(1);
            end
            if (!mm_known_r || $signed(req_r.power) < min_r) min_r <= req_r.power;
            if (!mm_known_r || $signed(req_r.power) > max_r) max_r <= req_r.power;
            mm_known_r <= 1'b1;
          end
          if (req_r.import_ok) begin imp_r <= req_r.import_energy; imp_k_r <= 1'b1; end
          if (req_r.export_ok) begin exp_r <= req_r.export_energy; exp_k_r <= 1'b1; end
        end
        bucket_r <= bkt;
        dq_r     <= sum_mag;
        dr_r     <= '0;
        step_r   <= '0;
      end
    end
  end

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> state_r == BK_IDLE || state_r == BK_MOD || state_r == BK_DECIDE)
    else $error("result pending outside idle path");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !q_rd) else $error("request taken while result waits");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> sum_r == '0) else $error("sum without samples");

endmodule

[sv/time_bucket_min_max_mean_aggregator.sv]
// top level of the time bucket min/max/mean aggregator
// Usage: requests enter on the in_ channel (valid/stall), one result beat
// per request leaves on the out_ channel. Samples are grouped into buckets
// of bucket_seconds; a bucket change or a flush request emits its record.
// Requests are taken into a two-entry queue by the front, so the source is
// only stalled when that queue is full. The back takes one request at a
// time: a bit-serial modulo for the bucket, a decide step and, for an emit,
// a serial division for the mean followed by a check and an output step.
// A result beat waits in the output register while out_stall is high; no
// further request is taken by the back meanwhile and the queue fills.
// Reset (rst_n low, synchronous) clears the aggregate, last written bucket
// and the configuration to its defaults. Configuration is written through
// the APB-style psel/penable port; the user must write it only while the
// block is idle, and the block itself has no check for this.
module time_bucket_min_max_mean_aggregator
  import tbma_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_epoch,
  input  logic signed [23:0] in_power,
  input  logic        in_power_ok,
  input  logic [31:0] in_import_energy,
  input  logic        in_import_ok,
  input  logic [31:0] in_export_energy,
  input  logic        in_export_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_bucket_start,
  output logic signed [23:0] out_mean_power,
  output logic signed [23:0] out_min_power,
  output logic signed [23:0] out_max_power_seen,
  output logic [31:0] out_import_out,
  output logic        out_import_known,
  output logic [31:0] out_export_out,
  output logic        out_export_known,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [16:0] bs_r;
  logic [22:0] mp_r;
  logic [31:0] me_r;
  req_t  req;
  req_t  q_data;
  res_t  res;
  logic  q_full, q_empty, q_rd, wr;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= BS_RESET;
      mp_r <= MP_RESET;
      me_r <= ME_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BUCKET_SECONDS: bs_r <= pwdata[16:0];
        REG_MAX_POWER:      mp_r <= pwdata[22:0];
        REG_MAX_ENERGY:     me_r <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_BUCKET_SECONDS: prdata = {15'd0, bs_r};
      REG_MAX_POWER:      prdata = {9'd0, mp_r};
      REG_MAX_ENERGY:     prdata = me_r;
      default:            prdata = 32'd0;
    endcase
  end

  // front: pack beat and push into the queue
  assign req = '{req_type: in_req_type, epoch: in_epoch, power: in_power,
                 power_ok: in_power_ok, import_energy: in_import_energy,
                 import_ok: in_import_ok, export_energy: in_export_energy,
                 export_ok: in_export_ok};
  assign in_stall = q_full;
  assign wr       = in_valid && !q_full;

  tbma_fifo u_fifo (
    .clk, .rst_n, .wr_en(wr), .wr_data(req), .full(q_full),
    .rd_en(q_rd), .rd_data(q_data), .empty(q_empty)
  );

  tbma_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .bucket_seconds(bs_r), .max_power(mp_r), .max_energy(me_r),
    .q_empty, .q_data, .q_rd, .out_valid, .out_stall, .out_res(res)
  );

  assign out_status         = res.status;
  assign out_bucket_start   = res.bucket_start;
  assign out_mean_power     = res.mean_power;
  assign out_min_power      = res.min_power;
  assign out_max_power_seen = res.max_power_seen;
  assign out_import_out     = res.import_out;
  assign out_import_known   = res.import_known;
  assign out_export_out     = res.export_out;
  assign out_export_known   = res.export_known;

endmodule

[bench/time_bucket_min_max_mean_aggregator_tb.sv]
// self-checking testbench of the time bucket min/max/mean aggregator
`timescale 1ns / 100ps

module time_bucket_min_max_mean_aggregator_tb
  import tbma_pkg::*;
();

  localparam int CNT_BITS = COUNT_BITS_DEF;
  localparam logic [31:0] BASE_T = 32'd1700000000;

  // bucket model: predicts the result beat of each request beat
  class bucket_scoreboard;
    logic [16:0] bsec;
    logic [22:0] pmax;
    logic [31:0] emax;
    bit          is_open;
    logic [31:0] open_start;
    longint      psum;
    longint      pcount;
    int          pmin;
    int          pmaxv;
    bit          have_min;
    bit          have_max;
    logic [31:0] imp;
    bit          imp_k;
    logic [31:0] exp_e;
    bit          exp_k;
    logic [31:0] last_out;
    res_t        pending[$];
    int          mismatches;

    function void clear_agg();
      is_open = 0;
      open_start = '0;
      psum = 0;
      pcount = 0;
      pmin = 0;
      pmaxv = 0;
      have_min = 0;
      have_max = 0;
      imp = '0;
      imp_k = 0;
      exp_e = '0;
      exp_k = 0;
    endfunction

    function void reset_all();
      bsec = BS_RESET;
      pmax = MP_RESET;
      emax = ME_RESET;
      clear_agg();
      last_out = '0;
      pending.delete();
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_BUCKET_SECONDS: bsec = val[16:0];
        REG_MAX_POWER:      pmax = val[22:0];
        default:            emax = val;
      endcase
    endfunction

    function longint absv(longint v);
      return v < 0 ? -v : v;
    endfunction

    // forms the record; emits it and clears when plausible
    function bit try_emit(output res_t r);
      longint mag;
      longint q;
      longint mean;
      bit ok;
      r = '0;
      mag = absv(psum);
      q = mag / pcount;
      mean = psum < 0 ? -q : q;
      ok = open_start >= MIN_STAMP && absv(mean) <= pmax && absv(pmin) <= pmax &&
           absv(pmaxv) <= pmax && pmin <= pmaxv && mean >= pmin && mean <= pmaxv &&
           (!imp_k || imp <= emax) && (!exp_k || exp_e <= emax);
      if (!ok) return 0;
      r.bucket_start = open_start;
      r.mean_power = mean[23:0];
      r.min_power = pmin[23:0];
      r.max_power_seen = pmaxv[23:0];
      r.import_out = imp_k ? imp : '0;
      r.import_known = imp_k;
      r.export_out = exp_k ? exp_e : '0;
      r.export_known = exp_k;
      last_out = open_start;
      clear_agg();
      return 1;
    endfunction

    function void note_request(req_t q);
      res_t r;
      logic [31:0] bs;
      logic [31:0] bkt;
      int p;
      bit emitted;
      r = '0;
      emitted = 0;
      if (q.req_type) begin
        if (!is_open || pcount == 0) r.status = ST_NOTHING;
        else if (try_emit(r)) r.status = ST_FLUSHED;
        else begin
          r = '0;
          r.status = ST_HELD;
        end
        pending.push_back(r);
        return;
      end
      bs = (bsec == 0) ? 32'd1 : {15'd0, bsec};
      bkt = q.epoch - (q.epoch % bs);
      p = $signed(q.power);
      if (bkt < last_out || (is_open && bkt < open_start)) begin
        r.status = ST_BACKWARDS;
        pending.push_back(r);
        return;
      end
      if (!is_open && last_out == bkt) begin
        r.status = ST_WRITTEN;
        pending.push_back(r);
        return;
      end
      if (is_open && bkt != open_start && pcount > 0) begin
        if (!try_emit(r)) begin
          r = '0;
          r.status = ST_HELD;
          pending.push_back(r);
          return;
        end
        emitted = 1;
      end
      if (!is_open) begin
        is_open = 1;
        open_start = bkt;
      end
      if (q.power_ok) begin
        if (pcount < (64'd1 << CNT_BITS) - 1) begin
          psum += p;
          pcount++;
        end
        if (!have_min || p < pmin) pmin = p;
        if (!have_max || p > pmaxv) pmaxv = p;
        have_min = 1;
        have_max = 1;
      end
      if (q.import_ok) begin
        imp = q.import_energy;
        imp_k = 1;
      end
      if (q.export_ok) begin
        exp_e = q.export_energy;
        exp_k = 1;
      end
      r.status = emitted ? ST_EMIT_ADD : ST_ADDED;
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [31:0] in_epoch;
  logic signed [23:0] in_power;
  logic        in_power_ok;
  logic [31:0] in_import_energy;
  logic        in_import_ok;
  logic [31:0] in_export_energy;
  logic        in_export_ok;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_bucket_start;
  logic signed [23:0] out_mean_power;
  logic signed [23:0] out_min_power;
  logic signed [23:0] out_max_power_seen;
  logic [31:0] out_import_out;
  logic        out_import_known;
  logic [31:0] out_export_out;
  logic        out_export_known;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bucket_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off;
  logic [31:0] cur_time;

  time_bucket_min_max_mean_aggregator uut (.*);

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stall, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.status = status_t'(out_status);
      r.bucket_start = out_bucket_start;
      r.mean_power = out_mean_power;
      r.min_power = out_min_power;
      r.max_power_seen = out_max_power_seen;
      r.import_out = out_import_out;
      r.import_known = out_import_known;
      r.export_out = out_export_out;
      r.export_known = out_export_known;
      sb.check_result(r);
    end
  end

  // register write: setup cycle then access cycle, then idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // offer one request beat and wait for acceptance; valid drops only when idling
  task automatic send_beat(req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= q.req_type;
    in_epoch <= q.epoch;
    in_power <= q.power;
    in_power_ok <= q.power_ok;
    in_import_energy <= q.import_energy;
    in_import_ok <= q.import_ok;
    in_export_energy <= q.export_energy;
    in_export_ok <= q.export_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(q);
  endtask

  task automatic sample(logic [31:0] t, logic [23:0] p, bit pok,
                        logic [31:0] ie, bit iok, logic [31:0] ee, bit eok);
    req_t q;
    q = '{req_type: 1'b0, epoch: t, power: p, power_ok: pok, import_energy: ie,
          import_ok: iok, export_energy: ee, export_ok: eok};
    send_beat(q);
  endtask

  task automatic flush_req();
    req_t q;
    q = '0;
    q.req_type = 1'b1;
    q.epoch = $urandom;
    q.power = 24'($urandom);
    send_beat(q);
  endtask

  // mostly plausible sample a little ahead in time
  task automatic random_sample();
    int k;
    logic [23:0] p;
    k = $urandom_range(99);
    if (k < 70) cur_time += $urandom_range(3);
    else if (k < 90) cur_time += $urandom_range(200);
    else if (k < 95) cur_time -= $urandom_range(300);
    if ($urandom_range(19) == 0) p = 24'($urandom);
    else p = 24'($urandom_range(800000) - 400000);
    sample(($urandom_range(49) == 0) ? $urandom : cur_time, p, $urandom_range(9) != 0,
           ($urandom_range(9) == 0) ? $urandom : $urandom_range(100000),
           $urandom_range(3) != 0,
           ($urandom_range(9) == 0) ? $urandom : $urandom_range(100000),
           $urandom_range(3) != 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_phase(int n, logic [16:0] bs, logic [22:0] pm, logic [31:0] em);
    drain();
    write_reg(REG_BUCKET_SECONDS, bs);
    write_reg(REG_MAX_POWER, pm);
    write_reg(REG_MAX_ENERGY, em);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) flush_req();
      else random_sample();
    end
  endtask

  // stimulus
  initial begin
    sb = new();
    sb.reset_all();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_epoch = '0;
    in_power = '0;
    in_power_ok = 1'b0;
    in_import_energy = '0;
    in_import_ok = 1'b0;
    in_export_energy = '0;
    in_export_ok = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_time = BASE_T;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rewritten bucket 0, empty flush, extremes
    sample(32'd0, 24'd5, 1, 0, 0, 0, 0);
    flush_req();
    sample(BASE_T, 24'h7fffff, 1, 32'hffffffff, 1, 32'd0, 1);
    sample(BASE_T + 1, 24'h800000, 1, 32'd1, 1, 32'd2, 0);
    sample(BASE_T + 120, 24'd100, 1, 0, 0, 0, 0);
    flush_req();
    sample(BASE_T + 240, 24'd10, 0, 32'd7, 1, 32'd9, 1);
    sample(BASE_T + 400, 24'd20, 1, 0, 0, 0, 0);
    sample(BASE_T + 401, -24'sd3, 1, 32'd5, 1, 32'd6, 1);
    sample(BASE_T + 100, 24'd1, 1, 0, 0, 0, 0);
    flush_req();
    flush_req();
    sample(BASE_T + 240, 24'd1, 1, 0, 0, 0, 0);
    sample(BASE_T - 60, 24'd1, 1, 0, 0, 0, 0);
    sample(32'hffffffff, 24'd50, 1, 32'd4000000001, 1, 0, 0);
    flush_req();
    drain();
    write_reg(REG_MAX_ENERGY, 32'hffffffff);
    flush_req();
    sample(32'hffffffff, -24'sd7, 1, 0, 1, 0, 1);
    flush_req();

    // random phases with pressure on the first
    send_idle_pct = 26;
    recv_idle_pct = 50;
    cur_time = BASE_T;
    drain();
    write_reg(REG_BUCKET_SECONDS, 17'd0);
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) random_sample();
    join
    // sender has truncated the time at 32 bits; restart low enough
    random_phase(200, 17'd1, 23'h7fffff, 32'd0);
    cur_time = BASE_T;
    send_idle_pct = 50;
    recv_idle_pct = 26;
    random_phase(220, 17'd60, 23'd400000, 32'd4000000000);
    cur_time = BASE_T + 32'd10000000;
    random_phase(200, 17'd86400 - 17'd86000, 23'd0, 32'hffffffff);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_time = BASE_T + 32'd20000000;
    random_phase(200, 17'h1ffff, 23'd300000, 32'd100000);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("time_bucket_min_max_mean_aggregator verification clean");
    else
      $display("time_bucket_min_max_mean_aggregator verification failed");
    $finish;
  end

  // overall limit
  initial begin
    #20ms;
    $display("time_bucket_min_max_mean_aggregator verification failed");
    $finish;
  end

endmodule

[files.f]
sv/tbma_pkg.sv
sv/tbma_fifo.sv
sv/tbma_back.sv
sv/time_bucket_min_max_mean_aggregator.sv
bench/time_bucket_min_max_mean_aggregator_tb.sv
